### hw/rtl/utf8_stream_decoder_defines.svh
// Assertion macros for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTH
`define U8SD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("u8sd assertion failed");
`define U8SD_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("u8sd assertion failed");
`else
`define U8SD_ASSERT(label, prop)
`define U8SD_ASSERT_NEXT(label, pre, post)
`endif

`endif

### hw/rtl/u8sd_pkg.sv
package u8sd_pkg;

   localparam int HoldDepth  = 5;
   localparam int BurstDepth = HoldDepth + 1;
   localparam int CpWidth    = 31;
   localparam int CountWidth = 3;

   typedef logic [7:0]            byte_type;
   typedef logic [CpWidth-1:0]    cp_type;
   typedef logic [CountWidth-1:0] count_type;

   // sequence length opened by a lead byte, zero for anything else
   function automatic count_type lead_length(input byte_type b);
      count_type len;
      len = '0;
      if (b[7:5] == 3'b110) begin
         len = count_type'(2);
      end else if (b[7:4] == 4'b1110) begin
         len = count_type'(3);
      end else if (b[7:3] == 5'b11110) begin
         len = count_type'(4);
      end else if (b[7:2] == 6'b111110) begin
         len = count_type'(5);
      end else if (b[7:1] == 7'b1111110) begin
         len = count_type'(6);
      end
      return len;
   endfunction

endpackage

### hw/rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder, original six-byte form, 31-bit code points.
// Input channel (req_*): one byte per transfer, req_end_of_buffer on the
// final byte of a buffer flushes anything still held.
// Result channel (rsp_*): one code point per transfer; rsp_run_last marks
// the last result caused by a given input byte. A byte can cause zero
// results (it was only stored) or up to six (five held bytes plus itself).
// The results of a byte are first held in the burst register, then passed
// one at a time to the result register that drives rsp_*.
// Throughput: one byte per cycle while each byte causes at most one result
// and rsp_stall is low; a byte causing several results holds the input while
// the single result port drains the burst register one entry a cycle, rsp_stall permitting.
// Reset clears the held sequence, the burst register and rsp_valid.
// While rsp_stall is high the current result holds; the decoder takes one
// more byte only if its pending burst is already empty, then, if that byte
// caused any result, raises req_stall until the result register frees up.
`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  u8sd_pkg::byte_type    req_data_byte,
   input  logic                  req_end_of_buffer,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output u8sd_pkg::cp_type      rsp_code_point,
   output logic                  rsp_run_last
);
   import u8sd_pkg::*;

   // held sequence
   byte_type  held_ff [HoldDepth];
   count_type held_count_ff, held_count_in;
   count_type exp_len_ff, exp_len_in;
   logic      held_we [HoldDepth];

   // burst register: results of the last accepted byte
   byte_type  burst_byte_ff [BurstDepth];
   byte_type  burst_byte_in [BurstDepth];
   count_type burst_cnt_ff, burst_cnt_in;
   count_type burst_idx_ff;
   logic      burst_dec_ff;
   cp_type    burst_word_ff;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   cp_type    rsp_code_point_ff;
   logic      rsp_run_last_ff;

   logic      accept;
   logic      is_cont, held, cont_path, complete, cont_store, raw_b, lead_store;
   count_type new_len;
   logic [31:0] acc;
   cp_type    decoded;
   logic      burst_has, burst_last, rsp_load;
   cp_type    head_value;

   // ---------------- decode of the incoming byte ----------------
   always_comb begin
      is_cont    = (req_data_byte[7:6] == 2'b10);
      held       = (held_count_ff != '0);
      new_len    = lead_length(req_data_byte);
      cont_path  = held && is_cont;
      complete   = cont_path && ((held_count_ff + count_type'(1)) == exp_len_ff);
      cont_store = cont_path && !complete && !req_end_of_buffer &&
                   (held_count_ff < count_type'(HoldDepth));
      raw_b      = (new_len == '0) || req_end_of_buffer;
      lead_store = !cont_path && !raw_b;

      // payload assembly, lead bits first
      acc = 32'(held_ff[0] & (8'h7F >> exp_len_ff));
      for (int k = 1; k < HoldDepth; k++) begin
         if (count_type'(k) < held_count_ff) begin
            acc = {acc[25:0], held_ff[k][5:0]};
         end
      end
      acc     = {acc[25:0], req_data_byte[5:0]};
      decoded = acc[CpWidth-1:0];

      // raw burst: held bytes in order, then the new byte
      for (int k = 0; k < HoldDepth; k++) begin
         if (count_type'(k) < held_count_ff) begin
            burst_byte_in[k] = held_ff[k];
         end else begin
            burst_byte_in[k] = req_data_byte;
         end
      end
      burst_byte_in[BurstDepth-1] = req_data_byte;

      if (complete) begin
         burst_cnt_in = count_type'(1);
      end else if (cont_store) begin
         burst_cnt_in = '0;
      end else if (cont_path) begin
         burst_cnt_in = held_count_ff + count_type'(1);
      end else begin
         burst_cnt_in = held_count_ff + count_type'(raw_b);
      end

      if (cont_store) begin
         held_count_in = held_count_ff + count_type'(1);
         exp_len_in    = exp_len_ff;
      end else if (lead_store) begin
         held_count_in = count_type'(1);
         exp_len_in    = new_len;
      end else begin
         held_count_in = '0;
         exp_len_in    = '0;
      end

      for (int k = 0; k < HoldDepth; k++) begin
         held_we[k] = accept &&
                      ((cont_store && (held_count_ff == count_type'(k))) ||
                       (lead_store && (k == 0)));
      end
   end

   // ---------------- burst drain and handshakes ----------------
   always_comb begin
      burst_has  = (burst_idx_ff != burst_cnt_ff);
      burst_last = ((burst_idx_ff + count_type'(1)) == burst_cnt_ff);
      rsp_load   = burst_has && (!rsp_valid_ff || !rsp_stall);
      req_stall  = burst_has && !(rsp_load && burst_last);
      accept     = req_valid && !req_stall;

      if (burst_dec_ff) begin
         head_value = burst_word_ff;
      end else begin
         head_value = cp_type'(burst_byte_ff[burst_idx_ff]);
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= '0;
         exp_len_ff    <= '0;
         burst_cnt_ff  <= '0;
         burst_idx_ff  <= '0;
         burst_dec_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            held_count_ff <= held_count_in;
            exp_len_ff    <= exp_len_in;
            burst_cnt_ff  <= burst_cnt_in;
            burst_idx_ff  <= '0;
            burst_dec_ff  <= complete;
         end else if (rsp_load) begin
            burst_idx_ff <= burst_idx_ff + count_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < HoldDepth; k++) begin
         if (held_we[k]) begin
            held_ff[k] <= req_data_byte;
         end
      end
      if (accept) begin
         burst_byte_ff <= burst_byte_in;
         burst_word_ff <= decoded;
      end
      if (rsp_load) begin
         rsp_code_point_ff <= head_value;
         rsp_run_last_ff   <= burst_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = rsp_code_point_ff;
   assign rsp_run_last   = rsp_run_last_ff;

   // ---------------- checks ----------------
   `U8SD_ASSERT(a_held_bound, held_count_ff <= count_type'(HoldDepth))
   `U8SD_ASSERT(a_len_ahead, (held_count_ff == '0) || (exp_len_ff > held_count_ff))
   `U8SD_ASSERT(a_burst_order, burst_idx_ff <= burst_cnt_ff)
   `U8SD_ASSERT_NEXT(a_flush_at_end, accept && req_end_of_buffer, held_count_ff == '0)

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import u8sd_pkg::*;

   typedef struct {
      cp_type code_point;
      logic   run_last;
   } code_result_type;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   byte_type req_data_byte;
   logic     req_end_of_buffer;
   logic     rsp_valid;
   logic     rsp_stall;
   cp_type   rsp_code_point;
   logic     rsp_run_last;

   // decoder shadow state
   byte_type held_seq [HoldDepth];
   int       held_n  = 0;
   int       seq_len = 0;
   cp_type   burst_cps [$];

   code_result_type pending_cps [$];
   int              errors     = 0;
   int              bytes_sent = 0;
   bit              quiet      = 1'b0;

   utf8_stream_decoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_point    (rsp_code_point),
      .rsp_run_last      (rsp_run_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
   endtask

   function automatic int lead_len(input byte_type b);
      casez (b)
         8'b110?????: return 2;
         8'b1110????: return 3;
         8'b11110???: return 4;
         8'b111110??: return 5;
         8'b1111110?: return 6;
         default:     return 0;
      endcase
   endfunction

   task automatic drain_held();
      for (int k = 0; k < held_n; k++) begin
         burst_cps.push_back(cp_type'(held_seq[k]));
      end
      held_n  = 0;
      seq_len = 0;
   endtask

   // code points (or raw bytes) produced by one byte, queued in order
   task automatic predict_decode(input byte_type b, input logic eob);
      cp_type          acc;
      int              len;
      logic            taken;
      code_result_type r;
      burst_cps.delete();
      taken = 1'b0;
      if (held_n > 0) begin
         if (b[7:6] == 2'b10) begin
            taken = 1'b1;
            if (held_n + 1 == seq_len) begin
               acc = cp_type'(held_seq[0] & (8'h7F >> seq_len));
               for (int k = 1; k < held_n; k++) begin
                  acc = (acc << 6) | cp_type'(held_seq[k][5:0]);
               end
               acc = (acc << 6) | cp_type'(b[5:0]);
               held_n  = 0;
               seq_len = 0;
               burst_cps.push_back(acc);
            end else if (eob || held_n >= HoldDepth) begin
               drain_held();
               burst_cps.push_back(cp_type'(b));
            end else begin
               held_seq[held_n] = b;
               held_n++;
            end
         end else begin
            // breaking byte: flush, then treat as a fresh byte
            drain_held();
         end
      end
      if (!taken) begin
         len = lead_len(b);
         if (len == 0 || eob) begin
            burst_cps.push_back(cp_type'(b));
         end else begin
            held_seq[0] = b;
            held_n      = 1;
            seq_len     = len;
         end
      end
      foreach (burst_cps[i]) begin
         r.code_point = burst_cps[i];
         r.run_last   = (i == burst_cps.size() - 1);
         pending_cps.push_back(r);
      end
   endtask

   task automatic send_byte(input byte_type b, input logic eob);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_buffer <= eob;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predict_decode(b, eob);
      bytes_sent++;
   endtask

   function automatic byte_type make_lead(input int len);
      byte_type prefix;
      byte_type payload;
      if (len == 1) begin
         return byte_type'($urandom_range(0, 127));
      end
      prefix  = byte_type'(8'hFF << (8 - len));
      payload = byte_type'($urandom) & (8'h7F >> len);
      return prefix | payload;
   endfunction

   function automatic byte_type make_cont();
      return {2'b10, 6'($urandom)};
   endfunction

   task automatic send_random_unit();
      int       kind;
      int       len;
      int       k;
      byte_type brk;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         // well-formed sequence, sometimes ending the buffer
         len = $urandom_range(1, 6);
         if (len == 1) begin
            send_byte(make_lead(1), $urandom_range(0, 7) == 0);
         end else begin
            send_byte(make_lead(len), 1'b0);
            for (int i = 1; i < len; i++) begin
               send_byte(make_cont(), (i == len - 1) && ($urandom_range(0, 7) == 0));
            end
         end
      end else if (kind < 75) begin
         // sequence broken by a non-continuation byte
         len = $urandom_range(2, 6);
         k   = $urandom_range(0, len - 2);
         send_byte(make_lead(len), 1'b0);
         repeat (k) send_byte(make_cont(), 1'b0);
         do brk = byte_type'($urandom); while (brk[7:6] == 2'b10);
         send_byte(brk, $urandom_range(0, 3) == 0);
      end else if (kind < 87) begin
         // buffer ends before the sequence is complete
         len = $urandom_range(2, 6);
         k   = $urandom_range(0, len - 2);
         send_byte(make_lead(len), k == 0);
         for (int i = 0; i < k; i++) begin
            send_byte(make_cont(), i == k - 1);
         end
      end else begin
         send_byte(byte_type'($urandom), $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic test_directed();
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      // largest six-byte value
      send_byte(8'hFD, 1'b0);
      repeat (5) send_byte(8'hBF, 1'b0);
      // completion on the final byte
      send_byte(8'hC2, 1'b0);
      send_byte(8'hA9, 1'b1);
      // five held bytes flushed by ASCII: six results
      send_byte(8'hFC, 1'b0);
      repeat (4) send_byte(8'h80, 1'b0);
      send_byte(8'h41, 1'b0);
      // lone continuation and the two invalid bytes
      send_byte(8'h80, 1'b0);
      send_byte(8'hFE, 1'b0);
      send_byte(8'hFF, 1'b0);
      // buffer ends mid-sequence
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b1);
      // lead as the final byte
      send_byte(8'hF0, 1'b1);
      // lead broken by another lead, which then completes
      send_byte(8'hF8, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'hA9, 1'b0);
   endtask

   task automatic test_random_traffic(input int n);
      int start;
      start = bytes_sent;
      quiet = 1'b0;
      while (bytes_sent - start < n) send_random_unit();
   endtask

   task automatic test_back_to_back(input int n);
      int start;
      start = bytes_sent;
      quiet = 1'b1;
      while (bytes_sent - start < n) send_random_unit();
      quiet = 1'b0;
   endtask

   // result side: random stall per transfer, then compare with the oldest prediction
   initial begin : result_check
      int              hold;
      code_result_type want;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 10);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         if (pending_cps.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_code_point));
         end else begin
            want = pending_cps.pop_front();
            if (rsp_code_point !== want.code_point) begin
               report_mismatch($sformatf("code_point %h, want %h",
                                         rsp_code_point, want.code_point));
            end
            if (rsp_run_last !== want.run_last) begin
               report_mismatch($sformatf("run_last %b, want %b (code_point %h)",
                                         rsp_run_last, want.run_last, want.code_point));
            end
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_data_byte     <= '0;
      req_end_of_buffer <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(45);
      test_back_to_back(30);
      test_random_traffic(45);
      req_valid <= 1'b0;
      while (pending_cps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (pending_cps.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_cps.size()));
      end
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
